/* design/assert_macros.svh */
// Assertion macros shared by the SHA-1 hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define SHA1BSH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1bsh: same-cycle check failed");

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define SHA1BSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1bsh: next-cycle check failed");

`endif

/* design/sha1bsh_pkg.sv */
// Shared types, codes and constants of the SHA-1 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha1bsh_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int NUM_WORDS   = 5;
    localparam int BLOCK_W     = 512;

    // Operation codes carried in tuser on the input side
    localparam logic [1:0] OP_ABSORB = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Source of a byte shifted into the block
    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    // Round function groups
    localparam logic [1:0] ROUND_CH  = 2'd0;
    localparam logic [1:0] ROUND_P1  = 2'd1;
    localparam logic [1:0] ROUND_MAJ = 2'd2;
    localparam logic [1:0] ROUND_P3  = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       shift_en;
        logic [1:0] shift_sel;
        logic       len_add;
        logic       start;
        logic       round_en;
        logic [1:0] round_kind;
        logic       chain_add;
        logic       out_load;
        logic [2:0] out_idx;
        logic       out_err;
        logic       out_last;
    } sha1bsh_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at56;
        logic len_wrap;
        logic out_free;
    } sha1bsh_sts_t;

    function automatic logic [31:0] round_const(input logic [1:0] kind);
        logic [31:0] k;
        case (kind)
            ROUND_CH:  k = 32'h5A827999;
            ROUND_P1:  k = 32'h6ED9EBA1;
            ROUND_MAJ: k = 32'h8F1BBCDC;
            default:   k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/sha1bsh_datapath.sv */
// Datapath: block shift line, round unit, chaining words, length and output register.
`timescale 1ns / 1ps
`default_nettype none

module sha1bsh_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sha1bsh_pkg::sha1bsh_cmd_t  cmd,
    output sha1bsh_pkg::sha1bsh_sts_t       sts,
    input  wire logic [7:0]                 data_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [31:0]                     out_word,
    output logic [2:0]                      out_idx,
    output logic                            out_ok,
    output logic                            out_last
);
    import sha1bsh_pkg::*;

    logic [BLOCK_W-1:0] blk_reg;
    logic [BLOCK_W-1:0] blk_next;
    logic [5:0]         fill_reg;
    logic [63:0]        len_reg;
    logic [31:0]        chain_reg [NUM_WORDS];
    logic [31:0]        work_reg  [NUM_WORDS];
    logic               out_valid_reg;
    logic [31:0]        out_word_reg;
    logic [2:0]         out_idx_reg;
    logic               out_ok_reg;
    logic               out_last_reg;

    logic [7:0]  byte_in;
    logic [5:0]  len_lsb;
    logic [31:0] sched_x;
    logic [31:0] w_new;
    logic [31:0] w_cur;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [31:0] sum_w [NUM_WORDS];

    // Length bytes go out most significant first, picked by the low fill bits
    assign len_lsb = {3'd7 - fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.shift_sel)
            SEL_DATA: byte_in = data_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_ZERO: byte_in = 8'h00;
            default:  byte_in = len_reg[len_lsb +: 8];
        endcase
    end

    // Word t sits at the top; words t+2, t+8, t+13 at fixed taps
    assign w_cur   = blk_reg[511:480];
    assign sched_x = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
    assign w_new   = {sched_x[30:0], sched_x[31]};

    always_comb
    begin
        case (cmd.round_kind) inside
            ROUND_CH:
                f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            ROUND_MAJ:
                f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                      | (work_reg[2] & work_reg[3]);
            ROUND_P1, ROUND_P3:
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default:
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
        endcase
    end

    assign t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] + w_cur
                 + round_const(cmd.round_kind);

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            sum_w[i] = chain_reg[i] + work_reg[i];
        end
    end

    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift_en)
        begin
            blk_next = {blk_reg[BLOCK_W-9:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            blk_next = {blk_reg[BLOCK_W-33:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                chain_reg[i] <= init_word(3'(i));
                work_reg[i]  <= init_word(3'(i));
            end
        end
        else
        begin
            if (cmd.start)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_reg[i] <= init_word(3'(i));
                    work_reg[i]  <= init_word(3'(i));
                end
            end
            else
            begin
                if (cmd.shift_en)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.len_add)
                begin
                    len_reg <= len_reg + 64'd8;
                end
                if (cmd.round_en)
                begin
                    work_reg[0] <= t_val;
                    work_reg[1] <= work_reg[0];
                    work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
                    work_reg[3] <= work_reg[2];
                    work_reg[4] <= work_reg[3];
                end
                else if (cmd.chain_add)
                begin
                    for (int i = 0; i < NUM_WORDS; i++)
                    begin
                        chain_reg[i] <= sum_w[i];
                        work_reg[i]  <= sum_w[i];
                    end
                end
            end
        end
    end

    // Output register: a loaded word waits here until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg <= cmd.out_err ? 32'h0 : chain_reg[cmd.out_idx];
            out_idx_reg  <= cmd.out_idx;
            out_ok_reg   <= !cmd.out_err;
            out_last_reg <= cmd.out_last;
        end
    end

    assign sts.fill_last = (fill_reg == 6'd63);
    assign sts.fill_at56 = (fill_reg == 6'd56);
    assign sts.len_wrap  = &len_reg[63:3];
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_idx   = out_idx_reg;
    assign out_ok    = out_ok_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* design/sha1bsh_ctrl.sv */
// Controller: item decode, padding sequence, round counter and digest emission.
`timescale 1ns / 1ps
`default_nettype none

module sha1bsh_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 in_op,
    output sha1bsh_pkg::sha1bsh_cmd_t       cmd,
    input  wire sha1bsh_pkg::sha1bsh_sts_t  sts
);
    import sha1bsh_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROUND  = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_PAD80  = 3'd3;
    localparam logic [2:0] S_PADZ   = 3'd4;
    localparam logic [2:0] S_PADLEN = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_ERR    = 3'd7;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       done_reg, done_next;
    logic       corrupt_reg, corrupt_next;

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        round_next   = round_reg;
        word_next    = word_reg;
        done_next    = done_reg;
        corrupt_next = corrupt_reg;
        in_ready     = 1'b0;
        cmd          = '0;

        if (round_reg < 7'd20)
        begin
            cmd.round_kind = ROUND_CH;
        end
        else if (round_reg < 7'd40)
        begin
            cmd.round_kind = ROUND_P1;
        end
        else if (round_reg < 7'd60)
        begin
            cmd.round_kind = ROUND_MAJ;
        end
        else
        begin
            cmd.round_kind = ROUND_P3;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_START:
                        begin
                            cmd.start    = 1'b1;
                            done_next    = 1'b0;
                            corrupt_next = 1'b0;
                        end
                        OP_ABSORB:
                        begin
                            if (done_reg || corrupt_reg)
                            begin
                                corrupt_next = 1'b1;
                            end
                            else
                            begin
                                cmd.shift_en  = 1'b1;
                                cmd.shift_sel = SEL_DATA;
                                cmd.len_add   = 1'b1;
                                if (sts.len_wrap)
                                begin
                                    corrupt_next = 1'b1;
                                end
                                if (sts.fill_last)
                                begin
                                    state_next = S_ROUND;
                                    ret_next   = S_IDLE;
                                end
                            end
                        end
                        OP_FINISH:
                        begin
                            if (corrupt_reg)
                            begin
                                state_next = S_ERR;
                            end
                            else if (done_reg)
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                state_next = S_PAD80;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = ret_reg;
            end
            S_PAD80:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = SEL_PAD;
                state_next    = S_PADZ;
                if (sts.fill_last)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_PADZ;
                end
            end
            S_PADZ:
            begin
                if (sts.fill_at56)
                begin
                    state_next = S_PADLEN;
                end
                else
                begin
                    cmd.shift_en  = 1'b1;
                    cmd.shift_sel = SEL_ZERO;
                    if (sts.fill_last)
                    begin
                        state_next = S_ROUND;
                        ret_next   = S_PADZ;
                    end
                end
            end
            S_PADLEN:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = SEL_LEN;
                if (sts.fill_last)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_idx  = word_reg;
                    cmd.out_last = (word_reg == WORD_LAST);
                    if (word_reg == WORD_LAST)
                    begin
                        word_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 3'd1;
                    end
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_err  = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            round_reg   <= '0;
            word_reg    <= '0;
            done_reg    <= 1'b0;
            corrupt_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            round_reg   <= round_next;
            word_reg    <= word_next;
            done_reg    <= done_next;
            corrupt_reg <= corrupt_next;
        end
    end

endmodule

`default_nettype wire

/* design/sha1_byte_stream_hasher_unit.sv */
// Top level of the streaming SHA-1 hasher: controller, datapath and checks.
// Absorb, start and ignored items complete in the idle state; an absorb that fills the block
// starts a compression (80 rounds on the single round unit, one chaining add).
// Finish pads one byte a cycle, except while a block compresses, with one or two compressions,
// then loads one digest word a cycle into the free output register; a repeat finish skips padding.
// Input bytes are held off while the round unit runs; a finish on a corrupt stream emits one error word.
// rst_n is asynchronous, active low: chaining words take the initial values, state clears.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sha1_byte_stream_hasher_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [sha1bsh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  wire logic [sha1bsh_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // [1:0] operation
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [sha1bsh_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [31:0] digest_word,
                                                                      // [34:32] word_index,
                                                                      // [39:35] zero
    output logic                                       m_axis_tuser,  // [0] ok
    output logic                                       m_axis_tlast   // last_word
);
    import sha1bsh_pkg::*;

    sha1bsh_cmd_t cmd;
    sha1bsh_sts_t sts;
    logic [31:0]  out_word;
    logic [2:0]   out_idx;

    // Decode items, sequence padding and rounds, and drive the datapath
    sha1bsh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Hold the block, run the rounds, and keep the next result in its output register
    sha1bsh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .data_byte (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word),
        .out_idx   (out_idx),
        .out_ok    (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, out_idx, out_word};

    // A word is only loaded when the output register is free or being drained
    `SHA1BSH_ASSERT_IMPLY(a_load_when_free, cmd.out_load, sts.out_free)
    // Byte shifts and rounds never share a cycle on the block shift line
    `SHA1BSH_ASSERT_IMPLY(a_shift_round_excl, cmd.shift_en, !cmd.round_en)
    // Rounds run only while input transfers are held off
    `SHA1BSH_ASSERT_IMPLY(a_round_busy, cmd.round_en, !s_axis_tready)
    // After a start transfer the input is ready again in the next cycle
    `SHA1BSH_ASSERT_NEXT(a_start_one_cycle,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_START), s_axis_tready)

endmodule

`default_nettype wire
